@@ sv/bmsa_pkg.sv @@
// shared constants and types for the byte-addressed memory block
// no dependencies; used by bmsa_ram and byte_memory_sized_access_copy
`default_nettype none

package bmsa_pkg;

    localparam int unsigned MEM_BYTES = 65536;
    localparam int unsigned ADDR_W    = $clog2(MEM_BYTES);
    localparam int unsigned CNT_W     = 17;

    localparam logic [CNT_W-1:0] COPY_MAX = CNT_W'(65536);

    typedef enum logic [1:0] {
        FN_LOAD  = 2'd0,
        FN_STORE = 2'd1,
        FN_COPY  = 2'd2,
        FN_NONE  = 2'd3
    } func_t;

    localparam logic [1:0] WD_BYTE = 2'd0;
    localparam logic [1:0] WD_HALF = 2'd1;
    localparam logic [1:0] WD_WORD = 2'd2;

endpackage

`default_nettype wire

@@ sv/bmsa_ram.sv @@
// byte-wide single-port-write, single-port-read synchronous ram
// read-first, registered read data; depends on bmsa_pkg for depth
`default_nettype none

module bmsa_ram
(
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [bmsa_pkg::ADDR_W-1:0]  waddr,
    input  wire logic [7:0]                   wdata,
    input  wire logic [bmsa_pkg::ADDR_W-1:0]  raddr,
    output logic      [7:0]                   rdata
);

    logic [7:0] mem [bmsa_pkg::MEM_BYTES];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ sv/byte_memory_sized_access_copy.sv @@
// top level: command sequencer around a byte-wide ram
// depends on bmsa_pkg and bmsa_ram
`default_nettype none

// Byte-addressed RAM with sized little-endian load/store and forward byte copy.
// A command is taken at a clock edge where start is high and busy is low; busy
// stays high until the result has been shown. Each command gives one result,
// shown for exactly one cycle with done high; load_ok and load_data are only
// meaningful in that cycle. The receiver cannot stall, so the result transfer
// always completes in the done cycle.
// The ram moves one byte per cycle through its single read and write port.
// A command moves its bytes in the run state, then passes through drain and
// done. A copy count saturates at 65536. A copy of 0 bytes, a load or store
// with an invalid width or out-of-range start, or an unused func moves no bytes.
// The next command can be taken in the cycle after done.
// A copy reads byte k while writing byte k-1; when those hit the same entry
// the written byte is forwarded, so overlapping runs replicate forward.
// Reset aborts any command in flight and returns to idle; the ram contents
// are not cleared and read as undefined until written.
module byte_memory_sized_access_copy
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  func,
    input  wire logic [31:0] address,
    input  wire logic [31:0] source_address,
    input  wire logic [31:0] write_data,
    input  wire logic [1:0]  width_sel,
    input  wire logic [16:0] byte_count,
    output logic             done,
    output logic [31:0]      load_data,
    output logic             load_ok
);

    localparam int unsigned AW = bmsa_pkg::ADDR_W;
    localparam int unsigned CW = bmsa_pkg::CNT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t                 state_reg,       state_next;
    bmsa_pkg::func_t        op_reg,          op_next;
    logic [31:0]            cur_reg,         cur_next;
    logic [31:0]            src_reg,         src_next;
    logic [31:0]            wdata_reg,       wdata_next;
    logic [CW-1:0]          left_reg,        left_next;
    logic [1:0]             idx_reg,         idx_next;
    logic [31:0]            acc_reg,         acc_next;
    logic                   ok_reg,          ok_next;
    logic                   s1_valid_reg,    s1_valid_next;
    logic                   s1_keep_reg,     s1_keep_next;
    logic [AW-1:0]          s1_dst_reg,      s1_dst_next;
    logic [1:0]             s1_idx_reg,      s1_idx_next;
    logic                   s1_fwd_reg,      s1_fwd_next;
    logic [7:0]             s1_fwd_data_reg, s1_fwd_data_next;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [7:0]             ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [7:0]             ram_rdata;

    logic                   accept;
    logic                   fn_valid_width;
    logic [CW-1:0]          width_n;
    logic [CW-1:0]          copy_n;
    logic [7:0]             s1_byte;
    logic                   copy_we;
    logic                   cur_in;
    logic                   src_in;

    bmsa_ram u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign accept = start && (state_reg == ST_IDLE);
    assign cur_in = cur_reg < 32'(bmsa_pkg::MEM_BYTES);
    assign src_in = src_reg < 32'(bmsa_pkg::MEM_BYTES);

    always_comb
    begin
        case (width_sel)
            bmsa_pkg::WD_BYTE: width_n = CW'(1);
            bmsa_pkg::WD_HALF: width_n = CW'(2);
            bmsa_pkg::WD_WORD: width_n = CW'(4);
            default:           width_n = '0;
        endcase
    end

    assign fn_valid_width = (width_n != '0) && (address < 32'(bmsa_pkg::MEM_BYTES));
    assign copy_n = (byte_count > bmsa_pkg::COPY_MAX) ? bmsa_pkg::COPY_MAX : byte_count;

    // byte returning from the ram, patched by the write it raced with
    assign s1_byte = s1_fwd_reg ? s1_fwd_data_reg : ram_rdata;
    assign copy_we = s1_valid_reg && s1_keep_reg && (op_reg == bmsa_pkg::FN_COPY);

    always_comb
    begin
        state_next       = state_reg;
        op_next          = op_reg;
        cur_next         = cur_reg;
        src_next         = src_reg;
        wdata_next       = wdata_reg;
        left_next        = left_reg;
        idx_next         = idx_reg;
        acc_next         = acc_reg;
        ok_next          = ok_reg;
        s1_valid_next    = 1'b0;
        s1_keep_next     = 1'b0;
        s1_dst_next      = s1_dst_reg;
        s1_idx_next      = s1_idx_reg;
        s1_fwd_next      = 1'b0;
        s1_fwd_data_next = s1_fwd_data_reg;

        ram_we    = copy_we;
        ram_waddr = s1_dst_reg;
        ram_wdata = s1_byte;
        ram_raddr = cur_reg[AW-1:0];

        // second half of a byte read: merge into the load word
        if (s1_valid_reg && (op_reg == bmsa_pkg::FN_LOAD))
        begin
            acc_next[{s1_idx_reg, 3'b000} +: 8] = s1_keep_reg ? s1_byte : 8'h00;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next    = bmsa_pkg::func_t'(func);
                    cur_next   = address;
                    src_next   = source_address;
                    wdata_next = write_data;
                    idx_next   = '0;
                    acc_next   = '0;
                    ok_next    = 1'b0;
                    case (bmsa_pkg::func_t'(func))
                        bmsa_pkg::FN_LOAD:
                        begin
                            left_next = fn_valid_width ? width_n : '0;
                            ok_next   = fn_valid_width;
                        end
                        bmsa_pkg::FN_STORE: left_next = fn_valid_width ? width_n : '0;
                        bmsa_pkg::FN_COPY:  left_next = copy_n;
                        default:            left_next = '0;
                    endcase
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (left_reg == '0)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    left_next = CW'(left_reg - CW'(1));
                    cur_next  = cur_reg + 32'd1;
                    case (op_reg)
                        bmsa_pkg::FN_LOAD:
                        begin
                            s1_valid_next = 1'b1;
                            s1_keep_next  = cur_in;
                            s1_idx_next   = idx_reg;
                            idx_next      = idx_reg + 2'd1;
                        end
                        bmsa_pkg::FN_STORE:
                        begin
                            ram_we     = cur_in;
                            ram_waddr  = cur_reg[AW-1:0];
                            ram_wdata  = wdata_reg[7:0];
                            wdata_next = {8'h00, wdata_reg[31:8]};
                        end
                        bmsa_pkg::FN_COPY:
                        begin
                            ram_raddr        = src_reg[AW-1:0];
                            src_next         = src_reg + 32'd1;
                            s1_valid_next    = 1'b1;
                            s1_keep_next     = cur_in && src_in;
                            s1_dst_next      = cur_reg[AW-1:0];
                            s1_fwd_next      = copy_we && (s1_dst_reg == src_reg[AW-1:0]);
                            s1_fwd_data_next = s1_byte;
                        end
                        default:
                        begin
                            left_next = '0;
                        end
                    endcase
                    if (left_reg == CW'(1))
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            op_reg          <= bmsa_pkg::FN_NONE;
            cur_reg         <= '0;
            src_reg         <= '0;
            wdata_reg       <= '0;
            left_reg        <= '0;
            idx_reg         <= '0;
            acc_reg         <= '0;
            ok_reg          <= 1'b0;
            s1_valid_reg    <= 1'b0;
            s1_keep_reg     <= 1'b0;
            s1_dst_reg      <= '0;
            s1_idx_reg      <= '0;
            s1_fwd_reg      <= 1'b0;
            s1_fwd_data_reg <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            cur_reg         <= cur_next;
            src_reg         <= src_next;
            wdata_reg       <= wdata_next;
            left_reg        <= left_next;
            idx_reg         <= idx_next;
            acc_reg         <= acc_next;
            ok_reg          <= ok_next;
            s1_valid_reg    <= s1_valid_next;
            s1_keep_reg     <= s1_keep_next;
            s1_dst_reg      <= s1_dst_next;
            s1_idx_reg      <= s1_idx_next;
            s1_fwd_reg      <= s1_fwd_next;
            s1_fwd_data_reg <= s1_fwd_data_next;
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = (state_reg == ST_DONE);
    assign load_data = acc_reg;
    assign load_ok   = ok_reg;

    a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_ok_only_load: assert property (@(posedge clk) disable iff (!rst_n)
        (done && load_ok) |-> (op_reg == bmsa_pkg::FN_LOAD))
        else $error("load_ok on a non-load command");

    a_zero_when_not_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !load_ok) |-> (load_data == 32'd0))
        else $error("nonzero load_data without load_ok");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !ram_we)
        else $error("ram write while idle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (busy && !done))
        else $error("command transfer did not start the sequencer");

endmodule

`default_nettype wire
